// ===== rtl/midpoint_line_rasterizer_macros.svh =====
// Assertion macros for the midpoint line rasterizer checker.
// Depends on nothing; included by the checker file only.
`ifndef MIDPOINT_LINE_RASTERIZER_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MLR_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MLR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/mlr_pkg.sv =====
// Shared types and constants of the midpoint line rasterizer.
// Depends on nothing; used by the interfaces, the core and the checker.
package mlr_pkg;

	// Width of the packed ARGB color.
	localparam int COLOR_BITS = 32;

	// Command codes carried in the op field.
	typedef enum logic {
		OP_START   = 1'b0,
		OP_ADVANCE = 1'b1
	} mlr_op_t;

endpackage

// ===== rtl/mlr_cmd_if.sv =====
// Command channel of the midpoint line rasterizer: valid/ready plus one item.
// Depends on mlr_pkg.
interface mlr_cmd_if
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();

	logic                         valid;
	logic                         ready;
	mlr_op_t                      op;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [COLOR_BITS-1:0]        line_color;

	modport source (
		output valid, op, start_x, start_y, end_x, end_y, line_color,
		input  ready
	);

	modport sink (
		input  valid, op, start_x, start_y, end_x, end_y, line_color,
		output ready
	);

endinterface

// ===== rtl/mlr_pix_if.sv =====
// Pixel channel of the midpoint line rasterizer: valid/ready plus one result.
// Depends on mlr_pkg.
interface mlr_pix_if
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) ();

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic [COLOR_BITS-1:0]        pixel_color;
	logic                         valid_res;
	logic                         last;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, valid_res, last,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, valid_res, last,
		output ready
	);

endinterface

// ===== rtl/mlr_core.sv =====
// Line state and per-item decision logic of the midpoint line rasterizer.
// Depends on mlr_pkg. The midpoint test is kept as an incremental decision term.
module mlr_core
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  mlr_op_t                      op,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic [COLOR_BITS-1:0]        line_color,
	output logic signed [COORD_BITS-1:0] pixel_x,
	output logic signed [COORD_BITS-1:0] pixel_y,
	output logic [COLOR_BITS-1:0]        pixel_color,
	output logic                         valid_res,
	output logic                         last
);

	// Differences need one extra bit; the decision term a few more for its sums.
	localparam int DW = COORD_BITS + 1;
	localparam int KW = COORD_BITS + 4;

	// Line state.
	logic                         busy_q;
	logic                         x_major_q;
	logic                         s_neg_q;
	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [COORD_BITS-1:0] stop_q;
	logic signed [KW-1:0]         dec_q;
	logic signed [KW-1:0]         inc_step_q;
	logic signed [KW-1:0]         inc_flat_q;
	logic [COLOR_BITS-1:0]        color_q;

	// Setup signals.
	logic signed [DW-1:0]         dx, dy, dx_abs, dy_abs;
	logic                         x_maj, swap, s_neg;
	logic signed [COORD_BITS-1:0] near_x, near_y, far_x, far_y, stop_new;
	logic signed [DW-1:0]         coef_a, coef_b;
	logic signed [KW-1:0]         a_k, b_k, inc_step_new, inc_flat_new;
	logic                         first_last;

	// Advance signals.
	logic                         step;
	logic signed [COORD_BITS-1:0] major, minor, major_next, minor_next;
	logic signed [COORD_BITS-1:0] adv_x, adv_y;
	logic signed [KW-1:0]         dec_next;
	logic                         adv_last;

	// Pick the major axis, order the endpoints along it and form the line terms.
	// The first endpoint lies on the line, so the first decision term reduces
	// to the diagonal increment and needs no product.
	always_comb begin
		dx     = DW'(end_x) - DW'(start_x);
		dy     = DW'(end_y) - DW'(start_y);
		dx_abs = dx[DW-1] ? -dx : dx;
		dy_abs = dy[DW-1] ? -dy : dy;
		x_maj  = (dx_abs >= dy_abs);
		swap   = x_maj ? (start_x > end_x) : (start_y > end_y);
		near_x = swap ? end_x : start_x;
		near_y = swap ? end_y : start_y;
		far_x  = swap ? start_x : end_x;
		far_y  = swap ? start_y : end_y;
		coef_a = DW'(far_y) - DW'(near_y);
		coef_b = DW'(near_x) - DW'(far_x);
		s_neg  = x_maj ? !(far_y > near_y) : !(far_x > near_x);
		a_k    = KW'(coef_a);
		b_k    = KW'(coef_b);
		if (x_maj) begin
			inc_step_new = a_k + (s_neg ? -b_k : b_k);
			inc_flat_new = a_k;
			stop_new     = far_x;
			first_last   = (near_x == far_x);
		end else begin
			inc_step_new = b_k + (s_neg ? -a_k : a_k);
			inc_flat_new = b_k;
			stop_new     = far_y;
			first_last   = (near_y == far_y);
		end
	end

	// Midpoint decision for the next pixel of the running line.
	always_comb begin
		if (x_major_q ^ s_neg_q) begin
			step = !dec_q[KW-1];
		end else begin
			step = dec_q[KW-1] || (dec_q == '0);
		end
		major      = x_major_q ? cur_x_q : cur_y_q;
		minor      = x_major_q ? cur_y_q : cur_x_q;
		major_next = major + COORD_BITS'(1);
		if (!step) begin
			minor_next = minor;
		end else if (s_neg_q) begin
			minor_next = minor - COORD_BITS'(1);
		end else begin
			minor_next = minor + COORD_BITS'(1);
		end
		adv_x    = x_major_q ? major_next : minor_next;
		adv_y    = x_major_q ? minor_next : major_next;
		dec_next = dec_q + (step ? inc_step_q : inc_flat_q);
		adv_last = (major_next == stop_q);
	end

	// Result of the item being processed.
	always_comb begin
		pixel_x     = '0;
		pixel_y     = '0;
		pixel_color = '0;
		valid_res   = 1'b0;
		last        = 1'b0;
		if (op == OP_START) begin
			pixel_x     = near_x;
			pixel_y     = near_y;
			pixel_color = line_color;
			valid_res   = 1'b1;
			last        = first_last;
		end else if (busy_q) begin
			pixel_x     = adv_x;
			pixel_y     = adv_y;
			pixel_color = color_q;
			valid_res   = 1'b1;
			last        = adv_last;
		end
	end

	// Busy flag: set by a line of more than one pixel, cleared on its last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			if (op == OP_START) begin
				busy_q <= !first_last;
			end else if (busy_q && adv_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Line registers, loaded on a start and stepped on an advance.
	always_ff @(posedge clk) begin
		if (load) begin
			if (op == OP_START) begin
				x_major_q  <= x_maj;
				s_neg_q    <= s_neg;
				cur_x_q    <= near_x;
				cur_y_q    <= near_y;
				stop_q     <= stop_new;
				dec_q      <= inc_step_new;
				inc_step_q <= inc_step_new;
				inc_flat_q <= inc_flat_new;
				color_q    <= line_color;
			end else if (busy_q) begin
				cur_x_q <= adv_x;
				cur_y_q <= adv_y;
				dec_q   <= dec_next;
			end
		end
	end

endmodule

// ===== rtl/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer: one pixel per command, one command per cycle while the pixel side accepts.
// Each command is registered in the input stage, then its pixel in the result register, which offers it.
// The decision update is combinational, so a new command can enter while the last one's pixel moves on.
// The output register lets a new command in while a pixel waits downstream.
// Reset (arst_n low, asynchronous) empties both stages and drops the line.
// Depends on mlr_pkg, mlr_cmd_if, mlr_pix_if and mlr_core.
module midpoint_line_rasterizer
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic  clk,
	input  logic  arst_n,
	mlr_cmd_if.sink   cmd,
	mlr_pix_if.source pix
);

	// Input register stage.
	logic                         valid_s1;
	mlr_op_t                      op_s1;
	logic signed [COORD_BITS-1:0] start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic [COLOR_BITS-1:0]        color_s1;

	// Result register.
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0]        pixel_color_q;
	logic                         valid_res_q, last_q;

	// Core results for the item in the input stage.
	logic signed [COORD_BITS-1:0] core_x, core_y;
	logic [COLOR_BITS-1:0]        core_color;
	logic                         core_valid_res, core_last;

	logic cmd_xfer, fire_s1;

	// The input stage moves on whenever the result register is free or drains.
	assign fire_s1   = valid_s1 && (!out_valid_q || pix.ready);
	assign cmd.ready = !valid_s1 || fire_s1;
	assign cmd_xfer  = cmd.valid && cmd.ready;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_xfer) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_s1      <= cmd.op;
			start_x_s1 <= cmd.start_x;
			start_y_s1 <= cmd.start_y;
			end_x_s1   <= cmd.end_x;
			end_y_s1   <= cmd.end_y;
			color_s1   <= cmd.line_color;
		end
	end

	mlr_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (fire_s1),
		.op          (op_s1),
		.start_x     (start_x_s1),
		.start_y     (start_y_s1),
		.end_x       (end_x_s1),
		.end_y       (end_y_s1),
		.line_color  (color_s1),
		.pixel_x     (core_x),
		.pixel_y     (core_y),
		.pixel_color (core_color),
		.valid_res   (core_valid_res),
		.last        (core_last)
	);

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pixel_x_q     <= core_x;
			pixel_y_q     <= core_y;
			pixel_color_q <= core_color;
			valid_res_q   <= core_valid_res;
			last_q        <= core_last;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.pixel_x     = pixel_x_q;
	assign pix.pixel_y     = pixel_y_q;
	assign pix.pixel_color = pixel_color_q;
	assign pix.valid_res   = valid_res_q;
	assign pix.last        = last_q;

endmodule

// ===== rtl/mlr_checker.sv =====
// Port-level checker for the midpoint line rasterizer, with its bind.
// Depends on mlr_pkg and midpoint_line_rasterizer_macros.svh.
`include "midpoint_line_rasterizer_macros.svh"

module mlr_checker
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_valid,
	input logic                  cmd_ready,
	input logic                  pix_valid,
	input logic                  pix_ready,
	input logic [COORD_BITS-1:0] pix_x,
	input logic [COORD_BITS-1:0] pix_y,
	input logic [COLOR_BITS-1:0] pix_color,
	input logic                  pix_valid_res,
	input logic                  pix_last
);

	logic [2*COORD_BITS+COLOR_BITS+1:0] pix_word;
	logic [1:0]                         outstanding_q;
	logic                               cmd_xfer, pix_xfer;

	assign pix_word = {pix_x, pix_y, pix_color, pix_valid_res, pix_last};
	assign cmd_xfer = cmd_valid && cmd_ready;
	assign pix_xfer = pix_valid && pix_ready;

	// Commands accepted but not yet delivered as pixels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 2'd0;
		end else if (cmd_xfer && !pix_xfer) begin
			outstanding_q <= outstanding_q + 2'd1;
		end else if (pix_xfer && !cmd_xfer) begin
			outstanding_q <= outstanding_q - 2'd1;
		end
	end

	// A stalled pixel stays offered and unchanged.
	`MLR_ASSERT_NEXT(a_pix_hold, clk, arst_n, pix_valid && !pix_ready, pix_valid)
	`MLR_ASSERT_NEXT(a_pix_stable, clk, arst_n, pix_valid && !pix_ready, $stable(pix_word))

	// With nothing in the result register the block always takes a command.
	`MLR_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !pix_valid, cmd_ready)

	// At most two commands are in flight: the input stage and the result register.
	`MLR_ASSERT_IMPL(a_in_flight, clk, arst_n, 1'b1, outstanding_q != 2'd3)

endmodule

bind midpoint_line_rasterizer mlr_checker #(
	.COORD_BITS (COORD_BITS)
) u_mlr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.pix_valid     (pix.valid),
	.pix_ready     (pix.ready),
	.pix_x         (pix.pixel_x),
	.pix_y         (pix.pixel_y),
	.pix_color     (pix.pixel_color),
	.pix_valid_res (pix.valid_res),
	.pix_last      (pix.last)
);

// ===== tb/mlr_pixel_checker.sv =====
// Pixel checker for the midpoint line rasterizer: watches both channels, traces lines itself
// and compares every pixel transfer with the oldest pending prediction.
// Depends on mlr_pkg, mlr_cmd_if and mlr_pix_if.
module mlr_pixel_checker
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	mlr_cmd_if   cmd,
	mlr_pix_if   pix,
	output int   mismatches,
	output int   pending,
	output int   pixels_seen,
	output int   idle_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]        color;
		logic                         valid_res;
		logic                         last;
	} pixel_t;

	// Predicted pixels, oldest first.
	pixel_t pixel_q[$];

	// Line tracer state: position, far end on the major axis and the implicit line terms.
	logic                  line_active = 1'b0;
	logic                  major_is_x  = 1'b0;
	logic                  step_down   = 1'b0;
	longint                cur_x       = 0;
	longint                cur_y       = 0;
	longint                far_major   = 0;
	longint                term_a      = 0;
	longint                term_b      = 0;
	longint                term_c      = 0;
	logic [COLOR_BITS-1:0] color_hold  = '0;

	// Advances the line tracer by one command and returns the pixel it must produce.
	function automatic pixel_t trace_pixel(mlr_op_t op,
			logic signed [COORD_BITS-1:0] sx, sy, ex, ey, logic [COLOR_BITS-1:0] color);
		longint x1, y1, x2, y2, adx, ady, tmp, s, k;
		logic   hit_far;
		logic   emit;
		pixel_t px;
		px      = '0;
		hit_far = 1'b0;
		emit    = 1'b1;
		if (op == OP_START) begin
			x1 = longint'(sx);
			y1 = longint'(sy);
			x2 = longint'(ex);
			y2 = longint'(ey);
			adx = (x2 > x1) ? x2 - x1 : x1 - x2;
			ady = (y2 > y1) ? y2 - y1 : y1 - y2;
			major_is_x = (adx >= ady);
			// Order the endpoints so that the major coordinate rises.
			if ((major_is_x && x1 > x2) || (!major_is_x && y1 > y2)) begin
				tmp = x1; x1 = x2; x2 = tmp;
				tmp = y1; y1 = y2; y2 = tmp;
			end
			term_a = y2 - y1;
			term_b = x1 - x2;
			term_c = x2 * y1 - x1 * y2;
			if (major_is_x) begin
				step_down = !(y2 > y1);
				far_major = x2;
			end else begin
				step_down = !(x2 > x1);
				far_major = y2;
			end
			color_hold  = color;
			cur_x       = x1;
			cur_y       = y1;
			hit_far     = major_is_x ? (cur_x == far_major) : (cur_y == far_major);
			line_active = !hit_far;
		end else if (line_active) begin
			// Midpoint decision at the pixel just emitted.
			s = step_down ? -1 : 1;
			if (major_is_x) begin
				k = term_a * (cur_x + 1) + term_b * (cur_y + s) + term_c;
				if ((s > 0) ? (k >= 0) : (k <= 0))
					cur_y += s;
				cur_x  += 1;
				hit_far = (cur_x == far_major);
			end else begin
				k = term_a * (cur_x + s) + term_b * (cur_y + 1) + term_c;
				if ((s > 0) ? (k <= 0) : (k >= 0))
					cur_x += s;
				cur_y  += 1;
				hit_far = (cur_y == far_major);
			end
			if (hit_far)
				line_active = 1'b0;
		end else begin
			emit = 1'b0;
		end
		if (emit) begin
			px.x         = cur_x[COORD_BITS-1:0];
			px.y         = cur_y[COORD_BITS-1:0];
			px.color     = color_hold;
			px.valid_res = 1'b1;
			px.last      = hit_far;
		end
		return px;
	endfunction

	// Prints one line per mismatch, up to a limit, and counts every one.
	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] pixel %0d: %s", $time, pixels_seen, msg);
		mismatches++;
	endtask

	// Predict on each command transfer, then compare each pixel transfer.
	always @(posedge clk) begin
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				pixel_q.push_back(trace_pixel(cmd.op, cmd.start_x, cmd.start_y,
					cmd.end_x, cmd.end_y, cmd.line_color));
			if (pix.valid && pix.ready) begin
				got.x         = pix.pixel_x;
				got.y         = pix.pixel_y;
				got.color     = pix.pixel_color;
				got.valid_res = pix.valid_res;
				got.last      = pix.last;
				if (pixel_q.size() == 0) begin
					report_mismatch("pixel transfer with no command pending");
				end else begin
					want = pixel_q.pop_front();
					if (got.x !== want.x)
						report_mismatch($sformatf("pixel_x is %0d, expected %0d",
							got.x, want.x));
					if (got.y !== want.y)
						report_mismatch($sformatf("pixel_y is %0d, expected %0d",
							got.y, want.y));
					if (got.color !== want.color)
						report_mismatch($sformatf("pixel_color is %h, expected %h",
							got.color, want.color));
					if (got.valid_res !== want.valid_res)
						report_mismatch($sformatf("valid_res is %b, expected %b",
							got.valid_res, want.valid_res));
					if (got.last !== want.last)
						report_mismatch($sformatf("last is %b, expected %b",
							got.last, want.last));
				end
				pixels_seen++;
				if (got.valid_res !== 1'b1)
					idle_seen++;
			end
			pending = pixel_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Top of the midpoint line rasterizer testbench: clock, reset, command stimulus,
// pixel back-pressure and the verdict. Depends on mlr_pkg, the channel interfaces,
// midpoint_line_rasterizer and mlr_pixel_checker.
module tb_top
	import mlr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB           = 12;
	localparam int COORD_MIN    = -(1 << (CB - 1));
	localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
	localparam int DIRECTED     = 25;
	localparam int RANDOM_ITEMS = 425;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	// Receiver stall patterns.
	typedef enum int {
		RX_OPEN,
		RX_HALF,
		RX_SPARSE,
		RX_DENSE
	} rx_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mlr_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
	mlr_pix_if #(.COORD_BITS(CB)) pix_ch ();

	int mismatches;
	int pending;
	int pixels_seen;
	int idle_seen;

	int   cycles        = 0;
	int   items_sent    = 0;
	int   lines_started = 0;
	int   advances_sent = 0;
	int   burst_left    = 0;
	int   gaps_blocked  = 0;
	logic hold_req;

	midpoint_line_rasterizer #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pix    (pix_ch)
	);

	mlr_pixel_checker #(.COORD_BITS(CB)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.pix         (pix_ch),
		.mismatches  (mismatches),
		.pending     (pending),
		.pixels_seen (pixels_seen),
		.idle_seen   (idle_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit: a stuck handshake ends the run here.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Number of pixels after the first one for a line between two endpoints.
	function automatic int span(int sx, int sy, int ex, int ey);
		int adx, ady;
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		return (adx > ady) ? adx : ady;
	endfunction

	// Offers one command until it transfers, then applies the burst and gap pattern.
	task automatic send_cmd(mlr_op_t op, logic signed [CB-1:0] sx, sy, ex, ey,
			logic [COLOR_BITS-1:0] color);
		int gap;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.op         <= op;
		cmd_ch.start_x    <= sx;
		cmd_ch.start_y    <= sy;
		cmd_ch.end_x      <= ex;
		cmd_ch.end_y      <= ey;
		cmd_ch.line_color <= color;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent++;
		if (op == OP_START)
			lines_started++;
		else
			advances_sent++;
		if (burst_left > 0)
			burst_left--;
		if (gaps_blocked > 0) begin
			gaps_blocked--;
		end else if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
	endtask

	// Advance carries random endpoint and color bits that the block must not use.
	task automatic send_advance();
		send_cmd(OP_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom),
			$urandom);
	endtask

	// Starts a line and walks it to its last pixel.
	task automatic draw(int sx, int sy, int ex, int ey, logic [COLOR_BITS-1:0] color);
		send_cmd(OP_START, CB'(sx), CB'(sy), CB'(ex), CB'(ey), color);
		repeat (span(sx, sy, ex, ey)) send_advance();
	endtask

	// Random short line; sometimes abandoned early, sometimes followed by idle advances.
	task automatic random_line(int reach);
		int sx, sy, ex, ey, len, walk, extra;
		logic signed [CB-1:0] raw;
		raw = CB'($urandom);
		sx  = int'(raw);
		raw = CB'($urandom);
		sy  = int'(raw);
		ex  = sx + int'($urandom_range(0, 2 * reach)) - reach;
		ey  = sy + int'($urandom_range(0, 2 * reach)) - reach;
		if (ex > COORD_MAX || ex < COORD_MIN)
			ex = 2 * sx - ex;
		if (ey > COORD_MAX || ey < COORD_MIN)
			ey = 2 * sy - ey;
		len  = span(sx, sy, ex, ey);
		walk = len;
		if (len > 0 && $urandom_range(0, 4) == 0)
			walk = $urandom_range(0, len - 1);
		extra = (walk == len && $urandom_range(0, 6) == 0) ? $urandom_range(1, 2) : 0;
		send_cmd(OP_START, CB'(sx), CB'(sy), CB'(ex), CB'(ey), $urandom);
		repeat (walk + extra) send_advance();
	endtask

	// Receiver: its own stall stretches, plus one long hold-off on request.
	initial begin
		int       hold_cnt;
		int       stretch_left;
		logic     hold_done;
		rx_mode_t mode;
		hold_cnt     = 0;
		stretch_left = 0;
		hold_done    = 1'b0;
		mode         = RX_OPEN;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				hold_cnt--;
				pix_ch.ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done    = 1'b1;
				hold_cnt     = LONG_HOLD;
				pix_ch.ready <= 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode         = rx_mode_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(4, 40);
				end
				stretch_left--;
				case (mode)
					RX_OPEN:   pix_ch.ready <= 1'b1;
					RX_HALF:   pix_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: pix_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   pix_ch.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	// Command stimulus and verdict.
	initial begin
		int r;
		int k;
		logic signed [CB-1:0] a, b, c, d;
		hold_req          <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.op         <= OP_START;
		cmd_ch.start_x    <= '0;
		cmd_ch.start_y    <= '0;
		cmd_ch.end_x      <= '0;
		cmd_ch.end_y      <= '0;
		cmd_ch.line_color <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: advance while idle, single point, both orderings on each axis,
		// diagonal, steep, abandoned lines and the coordinate extremes.
		send_advance();
		draw(5, 5, 5, 5, 32'h0000_0000);
		send_advance();
		draw(-3, 7, -1, 7, 32'hFFFF_FFFF);
		draw(2, -1, 1, -1, 32'h8000_0001);
		draw(-6, 3, -6, 1, 32'h7FFF_FFFE);
		draw(0, 0, 2, -2, 32'hA5A5_5A5A);
		draw(1, 1, 2, 4, 32'h5A5A_A5A5);
		send_cmd(OP_START, CB'(COORD_MIN), CB'(COORD_MIN), CB'(COORD_MAX), CB'(COORD_MAX),
			32'hFFFF_0000);
		send_advance();
		send_cmd(OP_START, CB'(COORD_MAX), CB'(COORD_MIN), CB'(COORD_MIN), CB'(COORD_MAX),
			32'h0000_FFFF);
		send_advance();
		draw(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 32'h1234_5678);

		// Random: mostly well-formed lines, some wide abandoned ones and loose advances.
		while (items_sent < DIRECTED + RANDOM_ITEMS) begin
			if (!hold_req && items_sent > DIRECTED + 150) begin
				hold_req     <= 1'b1;
				gaps_blocked = 40;
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				random_line(12);
			end else if (r < 75) begin
				random_line(60);
			end else if (r < 87) begin
				a = CB'($urandom);
				b = CB'($urandom);
				c = CB'($urandom);
				d = CB'($urandom);
				send_cmd(OP_START, a, b, c, d, $urandom);
				k = $urandom_range(0, 4);
				repeat (k) send_advance();
			end else begin
				k = $urandom_range(1, 3);
				repeat (k) send_advance();
			end
		end
		cmd_ch.valid <= 1'b0;

		// Let the checker record the last transfer before waiting for the pipeline to drain.
		@(posedge clk);
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d line starts and %0d advances, one long receiver hold-off included.",
			lines_started, advances_sent);
		$display("Compared %0d pixel transfers, %0d of them idle responses; %0d mismatches.",
			pixels_seen, idle_seen, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
